// ===== sv/ctu_pkg.sv =====
// package: shared constants, types and register codes for the cohesive traction block
`timescale 1ns / 1ps
package ctu_pkg;

    localparam int SEGMENTS_DEF = 1024;
    localparam int CFG_AW = 5;

    // register byte addresses
    localparam logic [CFG_AW-1:0] REG_N_STRENGTH = 5'd0;
    localparam logic [CFG_AW-1:0] REG_N_CRIT     = 5'd4;
    localparam logic [CFG_AW-1:0] REG_N_PEAK     = 5'd8;
    localparam logic [CFG_AW-1:0] REG_S_STRENGTH = 5'd12;
    localparam logic [CFG_AW-1:0] REG_S_CRIT     = 5'd16;
    localparam logic [CFG_AW-1:0] REG_S_PEAK     = 5'd20;
    localparam logic [CFG_AW-1:0] REG_MIX        = 5'd24;

    localparam logic [31:0] RST_STRENGTH = 32'd65536;
    localparam logic [30:0] RST_CRIT     = 31'd16777216;
    localparam logic [30:0] RST_PEAK     = 31'd3790443;
    localparam logic [3:0]  RST_MIX      = 4'd1;

    typedef struct packed {
        logic [31:0] n_strength;
        logic [30:0] n_crit;
        logic [30:0] n_peak;
        logic [31:0] s_strength;
        logic [30:0] s_crit;
        logic [30:0] s_peak;
        logic [3:0]  mix;
    } t_cfg;

    // divider request: 64-bit numerator over 32-bit denominator
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } t_div_rsp;

endpackage

// ===== sv/cohesive_traction_update.sv =====
// top level: cohesive traction update with per-segment history
`timescale 1ns / 1ps
// usage
//  s_axis: one request per item (segment, openings, normal, tangent, area);
//   s_axis_tready is high only while the block is idle, one item at a time
//  m_axis: one result per item (forces, energies, flags), held in an
//   output register until taken; a stalled receiver stops new requests
//  apb: seven registers at byte addresses 0..24, written while idle
//  the result follows the memory read, the setup, eight divisions in turn
//   on the shared bit-serial divider (64-bit quotients), the power steps
//   that raise both ratios to mix_exponent, the criterion and the three
//   force products; a new request is taken only after the previous
//   result has been taken by the receiver
//  peaks live in one memory of SEGMENTS words; a status memory of valid
//   and debond bits is cleared by a sweep over all SEGMENTS entries after
//   reset, during which no request is taken (register writes still are)
//  the same segment is never in flight twice, so no forwarding is needed
module cohesive_traction_update #(
    parameter int SEGMENTS = ctu_pkg::SEGMENTS_DEF,
    localparam int AW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // segment_index[9:0], normal_opening[41:10], shear_opening[73:42],
    // normal_x..z [89:74][105:90][121:106], tangent_x..z [137:122][153:138]
    // [169:154], area [201:170], zero fill to 208
    input  logic [207:0] s_axis_tdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // force_x[47:0], force_y[95:48], force_z[143:96], normal_energy[175:144],
    // shear_energy[207:176], damaged[208], debond_now[209], zero fill to 216
    output logic [215:0] m_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    typedef enum logic [9:0] {
        S_CLR  = 10'b0000000001,
        S_IDLE = 10'b0000000010,
        S_RD   = 10'b0000000100,
        S_UPD  = 10'b0000001000,
        S_DIV  = 10'b0000010000,
        S_POW  = 10'b0000100000,
        S_CRIT = 10'b0001000000,
        S_FMUL = 10'b0010000000,
        S_FOUT = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    // segment index modulo SEGMENTS by compare and subtract
    function automatic logic [AW-1:0] f_wrap(logic [9:0] seg);
        logic [31:0] v_r;
        v_r = {22'd0, seg};
        for (int k = 9; k >= 0; k--) begin
            if (v_r >= (32'(SEGMENTS) << k)) v_r = v_r - (32'(SEGMENTS) << k);
        end
        return AW'(v_r);
    endfunction

    ctu_pkg::t_cfg r_cfg;
    t_state        r_st;
    logic [AW-1:0] r_clr;
    logic [1:0]    r_status [SEGMENTS];
    logic [1:0]    r_stat_q;
    logic [AW-1:0] w_seg;

    // latched request
    logic [AW-1:0]     r_idx;
    logic signed [32:0] r_ncod, r_tcod;
    logic signed [15:0] r_nv [3];
    logic signed [15:0] r_tv [3];
    logic [31:0]       r_area;

    // working values
    logic [31:0] r_pn, r_pt;
    logic        r_deb, r_was;
    logic [2:0]  r_op;
    logic [63:0] r_sn, r_ss, r_tn, r_tt, r_en, r_es, r_qn, r_qs;
    logic [63:0] r_pwn, r_pws;
    logic [3:0]  r_pcnt;
    logic [1:0]  r_fc;
    logic signed [63:0] r_v [3];
    logic [47:0] r_f [3];
    logic [31:0] r_gi, r_gii;
    logic        r_dmg;

    logic [63:0] w_rd;
    ctu_pkg::t_div_req w_dreq;
    ctu_pkg::t_div_rsp w_drsp;

    assign w_seg = f_wrap(s_axis_tdata[9:0]);

    ctu_mem #(.SEGMENTS(SEGMENTS)) u_mem (
        .i_clk(i_clk), .i_rd_en(r_st == S_IDLE), .i_rd_addr(w_seg),
        .o_rd_data(w_rd), .i_wr_en(r_st == S_CRIT), .i_wr_addr(r_idx),
        .i_wr_data({r_pn, r_pt})
    );
    ctu_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    assign pready = 1'b1;
    assign s_axis_tready = (r_st == S_IDLE);
    assign m_axis_tvalid = (r_st == S_OUT);

    always_comb begin
        unique case (paddr)
            ctu_pkg::REG_N_STRENGTH: prdata = r_cfg.n_strength;
            ctu_pkg::REG_N_CRIT:     prdata = {1'b0, r_cfg.n_crit};
            ctu_pkg::REG_N_PEAK:     prdata = {1'b0, r_cfg.n_peak};
            ctu_pkg::REG_S_STRENGTH: prdata = r_cfg.s_strength;
            ctu_pkg::REG_S_CRIT:     prdata = {1'b0, r_cfg.s_crit};
            ctu_pkg::REG_S_PEAK:     prdata = {1'b0, r_cfg.s_peak};
            ctu_pkg::REG_MIX:        prdata = {28'd0, r_cfg.mix};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{ctu_pkg::RST_STRENGTH, ctu_pkg::RST_CRIT, ctu_pkg::RST_PEAK,
                       ctu_pkg::RST_STRENGTH, ctu_pkg::RST_CRIT, ctu_pkg::RST_PEAK,
                       ctu_pkg::RST_MIX};
        end else if (psel && penable && pwrite) begin
            unique case (paddr)
                ctu_pkg::REG_N_STRENGTH: r_cfg.n_strength <= pwdata;
                ctu_pkg::REG_N_CRIT:     r_cfg.n_crit <= pwdata[30:0];
                ctu_pkg::REG_N_PEAK:     r_cfg.n_peak <= pwdata[30:0];
                ctu_pkg::REG_S_STRENGTH: r_cfg.s_strength <= pwdata;
                ctu_pkg::REG_S_CRIT:     r_cfg.s_crit <= pwdata[30:0];
                ctu_pkg::REG_S_PEAK:     r_cfg.s_peak <= pwdata[30:0];
                ctu_pkg::REG_MIX:        r_cfg.mix <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // spans and clamped numerators per mode
    logic signed [32:0] w_nspan, w_sspan;
    logic [31:0] w_nsn, w_ssn, w_ndn, w_sdn;
    always_comb begin
        w_nspan = {2'b0, r_cfg.n_crit} - {2'b0, r_cfg.n_peak};
        w_sspan = {2'b0, r_cfg.s_crit} - {2'b0, r_cfg.s_peak};
        // crit - p clamped
        if ({1'b0, r_pn} > {2'b0, r_cfg.n_crit}) w_nsn = '0;
        else if (({2'b0, r_cfg.n_crit} - {1'b0, r_pn}) > w_nspan) w_nsn = w_nspan[31:0];
        else w_nsn = 32'({2'b0, r_cfg.n_crit} - {1'b0, r_pn});
        if ({1'b0, r_pt} > {2'b0, r_cfg.s_crit}) w_ssn = '0;
        else if (({2'b0, r_cfg.s_crit} - {1'b0, r_pt}) > w_sspan) w_ssn = w_sspan[31:0];
        else w_ssn = 32'({2'b0, r_cfg.s_crit} - {1'b0, r_pt});
        // p - peak_open clamped
        if ({1'b0, r_pn} < {2'b0, r_cfg.n_peak}) w_ndn = '0;
        else if (({1'b0, r_pn} - {2'b0, r_cfg.n_peak}) > w_nspan) w_ndn = w_nspan[31:0];
        else w_ndn = 32'({1'b0, r_pn} - {2'b0, r_cfg.n_peak});
        if ({1'b0, r_pt} < {2'b0, r_cfg.s_peak}) w_sdn = '0;
        else if (({1'b0, r_pt} - {2'b0, r_cfg.s_peak}) > w_sspan) w_sdn = w_sspan[31:0];
        else w_sdn = 32'({1'b0, r_pt} - {2'b0, r_cfg.s_peak});
    end

    logic w_nok, w_sok;
    assign w_nok = w_nspan > 0;
    assign w_sok = w_sspan > 0;

    logic [31:0] w_nmag, w_smag;
    assign w_nmag = r_ncod[32] ? 32'(-r_ncod) : r_ncod[31:0];
    assign w_smag = r_tcod[32] ? 32'(-r_tcod) : r_tcod[31:0];

    // next op starts in the cycle the previous one completes
    logic [2:0] w_op;
    assign w_op = (r_st == S_DIV && w_drsp.done) ? r_op + 3'd1 : r_op;

    // divider op sequence: sn, ss, tn, tt, en, es, qn, qs
    always_comb begin
        w_dreq = '0;
        w_dreq.start = 1'b0;
        unique case (w_op)
            3'd0: begin w_dreq.num = r_cfg.n_strength * w_nsn; w_dreq.den = w_nspan[31:0]; end
            3'd1: begin w_dreq.num = r_cfg.s_strength * w_ssn; w_dreq.den = w_sspan[31:0]; end
            3'd2: begin w_dreq.num = r_sn[31:0] * w_nmag; w_dreq.den = r_pn; end
            3'd3: begin w_dreq.num = r_ss[31:0] * w_smag; w_dreq.den = r_pt; end
            3'd4: begin w_dreq.num = r_cfg.n_strength * w_ndn; w_dreq.den = w_nspan[31:0]; end
            3'd5: begin w_dreq.num = r_cfg.s_strength * w_sdn; w_dreq.den = w_sspan[31:0]; end
            3'd6: begin w_dreq.num = {2'b0, w_ndn, 30'd0}; w_dreq.den = w_nspan[31:0]; end
            default: begin w_dreq.num = {2'b0, w_sdn, 30'd0}; w_dreq.den = w_sspan[31:0]; end
        endcase
        w_dreq.start = (r_st == S_UPD) || (r_st == S_DIV && w_drsp.done && r_op != 3'd7);
    end

    // energy scaling, the dissipation quotient fits in 32 bits
    logic [62:0] w_gn, w_gs;
    assign w_gn = r_en[31:0] * r_cfg.n_crit;
    assign w_gs = r_es[31:0] * r_cfg.s_crit;

    // signed tractions fit in 34 bits
    logic signed [33:0] w_tn_s, w_tt_s;
    assign w_tn_s = r_ncod[32] ? -$signed({2'b0, r_tn[31:0]}) : $signed({2'b0, r_tn[31:0]});
    assign w_tt_s = r_tcod[32] ? -$signed({2'b0, r_tt[31:0]}) : $signed({2'b0, r_tt[31:0]});

    logic signed [50:0] w_vs [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_vs[k] = w_tn_s * r_nv[k] + w_tt_s * r_tv[k];
        end
    end

    // mixed-mode criterion, with the debond mark already set
    logic w_kill;
    assign w_kill = r_deb || (r_cfg.mix != 0 && (r_pwn + r_pws) > (64'd1 << 30));

    logic [63:0] w_vmag;
    logic        w_vneg;
    logic [63:0] w_lo, w_hi, w_res;
    logic [47:0] w_fo;
    always_comb begin
        w_vneg = r_v[r_fc][63];
        w_vmag = (w_vneg ? 64'(-r_v[r_fc]) : 64'(r_v[r_fc])) >> 14;
        w_lo   = {32'd0, r_area} * {32'd0, w_vmag[31:0]};
        w_hi   = {32'd0, r_area} * {32'd0, w_vmag[63:32]};
        w_res  = (w_hi << 16) + (w_lo >> 16);
        if (w_vneg) w_fo = (w_res > 64'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : w_res[47:0];
        else w_fo = 48'(64'd0 - ((w_res > 64'h8000_0000_0000) ? 64'h8000_0000_0000 : w_res));
    end

    // power steps: both factors stay at or below 1.0 in Q2.30
    logic [61:0] w_pmul;
    assign w_pmul = r_pwn[30:0] * r_qn[30:0];
    logic [61:0] w_pmus;
    assign w_pmus = r_pws[30:0] * r_qs[30:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_CLR;
            r_clr <= '0;
        end else begin
            unique case (r_st)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(SEGMENTS - 1)) r_st <= S_IDLE;
                end
                S_IDLE: if (s_axis_tvalid) r_st <= S_RD;
                S_RD:   r_st <= S_UPD;
                S_UPD:  r_st <= S_DIV;
                S_DIV:  if (w_drsp.done && r_op == 3'd7) r_st <= S_POW;
                S_POW:  if (r_pcnt == r_cfg.mix) r_st <= S_CRIT;
                S_CRIT: r_st <= S_FMUL;
                S_FMUL: r_st <= S_FOUT;
                S_FOUT: if (r_fc == 2'd2) r_st <= S_OUT; else r_st <= S_FMUL;
                S_OUT:  if (m_axis_tready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_CLR) r_status[r_clr] <= 2'b00;
        else if (r_st == S_CRIT) r_status[r_idx] <= {w_kill, 1'b1};
        if (r_st == S_IDLE) r_stat_q <= r_status[w_seg];
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            S_IDLE: begin
                r_idx  <= w_seg;
                r_ncod <= {s_axis_tdata[41], s_axis_tdata[41:10]};
                r_tcod <= {s_axis_tdata[73], s_axis_tdata[73:42]};
                r_nv[0] <= s_axis_tdata[89:74];
                r_nv[1] <= s_axis_tdata[105:90];
                r_nv[2] <= s_axis_tdata[121:106];
                r_tv[0] <= s_axis_tdata[137:122];
                r_tv[1] <= s_axis_tdata[153:138];
                r_tv[2] <= s_axis_tdata[169:154];
                r_area  <= s_axis_tdata[201:170];
            end
            S_RD: begin
                // pure-mode checks and peak update on the read history
                logic [31:0] v_pn, v_pt;
                logic        v_deb;
                v_pn  = r_stat_q[0] ? w_rd[63:32] : {1'b0, r_cfg.n_peak};
                v_pt  = r_stat_q[0] ? w_rd[31:0]  : {1'b0, r_cfg.s_peak};
                v_deb = r_stat_q[1];
                r_was <= r_stat_q[1];
                if (!r_ncod[32] && r_ncod != 0) begin
                    if (r_ncod > $signed({2'b0, r_cfg.n_crit})) begin
                        v_pn = {1'b0, r_cfg.n_crit};
                        v_deb = 1'b1;
                    end else if (r_ncod[31:0] > v_pn) v_pn = r_ncod[31:0];
                end
                if (w_smag > {1'b0, r_cfg.s_crit}) begin
                    v_pt = {1'b0, r_cfg.s_crit};
                    v_deb = 1'b1;
                end else if (w_smag > v_pt) v_pt = w_smag;
                r_pn <= v_pn;
                r_pt <= v_pt;
                r_deb <= v_deb;
                r_op <= 3'd0;
            end
            S_DIV: if (w_drsp.done) begin
                unique case (r_op)
                    3'd0: r_sn <= w_nok ? w_drsp.quo : 64'd0;
                    3'd1: r_ss <= w_sok ? w_drsp.quo : 64'd0;
                    3'd2: r_tn <= (r_pn == 0 || r_ncod[32] || r_ncod == 0
                                   || r_ncod > $signed({2'b0, r_cfg.n_crit})) ? 64'd0 : w_drsp.quo;
                    3'd3: r_tt <= (r_pt == 0 || w_smag > {1'b0, r_cfg.s_crit})
                                  ? 64'd0 : w_drsp.quo;
                    3'd4: r_en <= w_nok ? w_drsp.quo : 64'd0;
                    3'd5: r_es <= w_sok ? w_drsp.quo : 64'd0;
                    3'd6: r_qn <= w_nok ? w_drsp.quo : 64'd0;
                    default: r_qs <= w_sok ? w_drsp.quo : 64'd0;
                endcase
                r_op <= r_op + 3'd1;
                r_pwn <= 64'd1 << 30;
                r_pws <= 64'd1 << 30;
                r_pcnt <= '0;
            end
            S_POW: if (r_pcnt != r_cfg.mix) begin
                r_pwn <= {32'd0, w_pmul[61:30]};
                r_pws <= {32'd0, w_pmus[61:30]};
                r_pcnt <= r_pcnt + 4'd1;
            end
            S_CRIT: begin
                r_deb <= w_kill;
                for (int k = 0; k < 3; k++) begin
                    r_v[k] <= w_kill ? 64'sd0 : 64'(w_vs[k]);
                end
                r_gi  <= (r_pn > {1'b0, r_cfg.n_peak})
                         ? ((|w_gn[62:57]) ? 32'hFFFF_FFFF : w_gn[56:25]) : 32'd0;
                r_gii <= (r_pt > {1'b0, r_cfg.s_peak})
                         ? ((|w_gs[62:57]) ? 32'hFFFF_FFFF : w_gs[56:25]) : 32'd0;
                r_dmg <= (r_pn > {1'b0, r_cfg.n_peak}) || (r_pt > {1'b0, r_cfg.s_peak});
                r_fc  <= 2'd0;
            end
            S_FMUL: r_f[r_fc] <= w_fo;
            S_FOUT: r_fc <= r_fc + 2'd1;
            default: ;
        endcase
    end

    assign m_axis_tdata = {6'd0, r_deb & ~r_was, r_dmg, r_gii, r_gi, r_f[2], r_f[1], r_f[0]};
endmodule

// ===== sv/ctu_div.sv =====
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module ctu_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ctu_pkg::t_div_req i_req,
    output ctu_pkg::t_div_rsp o_rsp
);
    logic [63:0] r_quo, n_quo;
    logic [31:0] r_rem;
    logic [32:0] n_rem;
    logic [31:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] w_sh;

    always_comb begin
        w_sh  = {r_rem, r_quo[63]};
        n_quo = {r_quo[62:0], 1'b0};
        n_rem = w_sh;
        if (w_sh >= {1'b0, r_den}) begin
            n_rem    = w_sh - {1'b0, r_den};
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem[31:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule

// ===== sv/ctu_mem.sv =====
// segment history memory of peak openings, one read and one write port
`timescale 1ns / 1ps
module ctu_mem #(
    parameter int SEGMENTS = ctu_pkg::SEGMENTS_DEF,
    localparam int AW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [63:0]   o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [63:0]   i_wr_data
);
    logic [63:0] r_mem [SEGMENTS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[i_wr_addr] <= i_wr_data;
        if (i_rd_en) o_rd_data <= r_mem[i_rd_addr];
    end
endmodule

// ===== verif/cohesive_traction_update_test.sv =====
// testbench: cohesive traction update checked against a built-in traction predictor
`timescale 1ns / 1ps
module cohesive_traction_update_test;

    localparam int  SEG      = ctu_pkg::SEGMENTS_DEF;
    localparam int  LIMIT    = 6000000;
    localparam int  N_RANDOM = 1500;

    typedef struct {
        logic [47:0] fx, fy, fz;
        logic [31:0] gn, gs;
        logic        dmg, deb;
    } t_traction;

    // predictor of the block: register copy, per-segment history, expected results
    class traction_board;
        logic [31:0] n_str, s_str;
        logic [30:0] n_crit, n_pk, s_crit, s_pk;
        logic [3:0]  mix;
        logic [31:0] hist_n [SEG];
        logic [31:0] hist_s [SEG];
        logic [1:0]  seg_st [SEG];
        t_traction   pending [$];
        int          errors;

        function new();
            n_str = ctu_pkg::RST_STRENGTH; s_str = ctu_pkg::RST_STRENGTH;
            n_crit = ctu_pkg::RST_CRIT; s_crit = ctu_pkg::RST_CRIT;
            n_pk = ctu_pkg::RST_PEAK; s_pk = ctu_pkg::RST_PEAK;
            mix = ctu_pkg::RST_MIX;
            errors = 0;
            for (int i = 0; i < SEG; i++) begin
                seg_st[i] = 2'b00;
                hist_n[i] = '0;
                hist_s[i] = '0;
            end
        endfunction

        function void set_reg(logic [4:0] addr, logic [31:0] val);
            case (addr)
                ctu_pkg::REG_N_STRENGTH: n_str  = val;
                ctu_pkg::REG_N_CRIT:     n_crit = val[30:0];
                ctu_pkg::REG_N_PEAK:     n_pk   = val[30:0];
                ctu_pkg::REG_S_STRENGTH: s_str  = val;
                ctu_pkg::REG_S_CRIT:     s_crit = val[30:0];
                ctu_pkg::REG_S_PEAK:     s_pk   = val[30:0];
                ctu_pkg::REG_MIX:        mix    = val[3:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] clamp_to(longint x, longint span);
            if (x < 0) return 64'd0;
            if (x > span) return 64'(span);
            return 64'(x);
        endfunction

        function logic [31:0] softened(logic [31:0] str, logic [30:0] c, logic [30:0] u,
                                       logic [31:0] p);
            longint span;
            logic [63:0] num;
            span = longint'({1'b0, c}) - longint'({1'b0, u});
            if (span <= 0) return 32'd0;
            num = clamp_to(longint'({1'b0, c}) - longint'({32'b0, p}), span);
            return 32'(({32'b0, str} * num) / 64'(span));
        endfunction

        function logic [63:0] dmg_num(logic [30:0] c, logic [30:0] u, logic [31:0] p,
                                      output logic [63:0] span_o);
            longint span;
            span = longint'({1'b0, c}) - longint'({1'b0, u});
            if (span <= 0) begin
                span_o = 64'd0;
                return 64'd0;
            end
            span_o = 64'(span);
            return clamp_to(longint'({32'b0, p}) - longint'({1'b0, u}), span);
        endfunction

        function logic [31:0] dissipated(logic [31:0] str, logic [30:0] c, logic [30:0] u,
                                         logic [31:0] p);
            logic [63:0] span, num, e, g;
            num = dmg_num(c, u, p, span);
            if (span == 0) return 32'd0;
            e = ({32'b0, str} * num) / span;
            g = (e * {33'b0, c}) >> 25;
            return (g > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : g[31:0];
        endfunction

        function logic [63:0] frac_pow(logic [30:0] c, logic [30:0] u, logic [31:0] p,
                                       logic [3:0] n);
            logic [63:0] span, num, q, r;
            num = dmg_num(c, u, p, span);
            q = (span != 0) ? (num << 30) / span : 64'd0;
            r = 64'd1 << 30;
            for (int i = 0; i < n; i++) r = (r * q) >> 30;
            return r;
        endfunction

        function longint trac(logic [31:0] s, longint cod, logic [31:0] p);
            logic [63:0] mag, t;
            if (p == 0) return 0;
            mag = (cod < 0) ? 64'(-cod) : 64'(cod);
            t = ({32'b0, s} * mag) / {32'b0, p};
            return (cod < 0) ? -longint'(t) : longint'(t);
        endfunction

        function logic [47:0] force_of(longint tn, longint nc, longint tt, longint tc,
                                       logic [63:0] area);
            longint v;
            logic neg;
            logic [63:0] mag, lo, hi, res, fmax;
            fmax = (64'd1 << 47) - 1;
            v = tn * nc + tt * tc;
            neg = (v < 0);
            mag = (neg ? 64'(-v) : 64'(v)) >> 14;
            lo = area * {32'b0, mag[31:0]};
            hi = area * (mag >> 32);
            res = (hi << 16) + (lo >> 16);
            if (neg) begin
                if (res > fmax) res = fmax;
                return res[47:0];
            end
            if (res > fmax + 1) res = fmax + 1;
            return 48'(64'd0 - res);
        endfunction

        // work out the expected result of one accepted request
        function void note_request(logic [207:0] d);
            int idx;
            longint ncod, tcod, nx, ny, nz, tx, ty, tz, tn, tt;
            logic [63:0] area, at, sum;
            logic [31:0] pn, pt;
            logic was_deb, deb;
            t_traction r;
            idx  = int'(d[9:0]) % SEG;
            ncod = longint'($signed(d[41:10]));
            tcod = longint'($signed(d[73:42]));
            nx = longint'($signed(d[89:74]));
            ny = longint'($signed(d[105:90]));
            nz = longint'($signed(d[121:106]));
            tx = longint'($signed(d[137:122]));
            ty = longint'($signed(d[153:138]));
            tz = longint'($signed(d[169:154]));
            area = {32'b0, d[201:170]};
            pn = seg_st[idx][0] ? hist_n[idx] : {1'b0, n_pk};
            pt = seg_st[idx][0] ? hist_s[idx] : {1'b0, s_pk};
            was_deb = seg_st[idx][1];
            deb = was_deb;
            tn = 0;
            tt = 0;
            if (ncod > 0) begin
                if (ncod > longint'({1'b0, n_crit})) begin
                    pn = {1'b0, n_crit};
                    deb = 1'b1;
                end else begin
                    if (ncod > longint'({32'b0, pn})) pn = 32'(ncod);
                    tn = trac(softened(n_str, n_crit, n_pk, pn), ncod, pn);
                end
            end
            at = (tcod < 0) ? 64'(-tcod) : 64'(tcod);
            if (at > {33'b0, s_crit}) begin
                pt = {1'b0, s_crit};
                deb = 1'b1;
            end else if (at > 0) begin
                if (at > {32'b0, pt}) pt = at[31:0];
                tt = trac(softened(s_str, s_crit, s_pk, pt), tcod, pt);
            end
            r.gn = (pn > {1'b0, n_pk}) ? dissipated(n_str, n_crit, n_pk, pn) : 32'd0;
            r.gs = (pt > {1'b0, s_pk}) ? dissipated(s_str, s_crit, s_pk, pt) : 32'd0;
            r.dmg = (pn > {1'b0, n_pk}) || (pt > {1'b0, s_pk});
            if (deb) begin
                tn = 0;
                tt = 0;
            end else if (mix > 0) begin
                // mixed-mode energy criterion
                sum = frac_pow(n_crit, n_pk, pn, mix) + frac_pow(s_crit, s_pk, pt, mix);
                if (sum > (64'd1 << 30)) begin
                    deb = 1'b1;
                    tn = 0;
                    tt = 0;
                end
            end
            hist_n[idx] = pn;
            hist_s[idx] = pt;
            seg_st[idx] = {deb, 1'b1};
            r.fx = force_of(tn, nx, tt, tx, area);
            r.fy = force_of(tn, ny, tt, ty, area);
            r.fz = force_of(tn, nz, tt, tz, area);
            r.deb = deb && !was_deb;
            pending.push_back(r);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("mismatch %s: got %h want %h", what, got, want);
        endtask

        task check_result(logic [215:0] d);
            t_traction w;
            if (pending.size() == 0) begin
                report("unexpected result", d[63:0], 64'd0);
                return;
            end
            w = pending.pop_front();
            if (d[47:0]    !== w.fx)  report("force_x", d[47:0], w.fx);
            if (d[95:48]   !== w.fy)  report("force_y", d[95:48], w.fy);
            if (d[143:96]  !== w.fz)  report("force_z", d[143:96], w.fz);
            if (d[175:144] !== w.gn)  report("normal_energy", d[175:144], w.gn);
            if (d[207:176] !== w.gs)  report("shear_energy", d[207:176], w.gs);
            if (d[208]     !== w.dmg) report("damaged", d[208], w.dmg);
            if (d[209]     !== w.deb) report("debond_now", d[209], w.deb);
        endtask
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic [207:0] s_axis_tdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [215:0] m_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    traction_board board = new();
    int idle_pct  = 0;   // sender gap odds, percent
    int stall_pct = 0;   // receiver stall odds, percent
    int cycles    = 0;

    cohesive_traction_update dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // timeout guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: check accepted results, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= stall_pct);
    end

    task automatic reg_write(logic [4:0] addr, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        board.set_reg(addr, val);
    endtask

    task automatic send_request(logic [9:0] seg, logic [31:0] nop, logic [31:0] sop,
                                logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                                logic [15:0] tx, logic [15:0] ty, logic [15:0] tz,
                                logic [31:0] area);
        logic [207:0] d;
        d = {6'b0, area, tz, ty, tx, nz, ny, nx, sop, nop, seg};
        @(posedge i_clk);
        while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        s_axis_tdata <= d;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_request(d);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(5))
            0:       return 16'sd16384;
            1:       return -16'sd16384;
            default: return 16'(int'($urandom_range(32768)) - 16384);
        endcase
    endfunction

    function automatic logic [31:0] rand_open(logic [30:0] crit, logic [30:0] pk);
        case ($urandom_range(11))
            0:       return $urandom;
            1:       return -32'($urandom_range(0, crit));
            2:       return 32'd0;
            3:       return {1'b0, crit};
            4:       return {1'b0, crit} + 32'($urandom_range(1, 64));
            5:       return 32'($urandom_range(0, pk));
            default: return 32'($urandom_range(0, crit));
        endcase
    endfunction

    function automatic logic [31:0] rand_area();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return 32'hFFFF_FFFF;
            default: return 32'($urandom_range(0, 32'h000F_FFFF));
        endcase
    endfunction

    task automatic random_items(int count, int seg_span);
        logic [9:0] seg;
        for (int i = 0; i < count; i++) begin
            idle_pct  = (i % 200 < 50) ? 0 : (i % 200 < 100) ? 49 : (i % 200 < 150) ? 0 : 33;
            stall_pct = (i % 200 < 50) ? 0 : (i % 200 < 100) ? 0 : (i % 200 < 150) ? 49 : 33;
            // mostly a small pool so segments build up history
            seg = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(0, seg_span));
            send_request(seg, rand_open(board.n_crit, board.n_pk),
                         ($urandom_range(3) == 0) ? 32'd0 : rand_open(board.s_crit, board.s_pk),
                         rand_comp(), rand_comp(), rand_comp(),
                         rand_comp(), rand_comp(), rand_comp(), rand_area());
        end
    endtask

    task automatic load_regs(logic [31:0] ns, logic [30:0] nc, logic [30:0] np,
                             logic [31:0] ss, logic [30:0] sc, logic [30:0] sp,
                             logic [3:0] mx);
        drain();
        reg_write(ctu_pkg::REG_N_STRENGTH, ns);
        reg_write(ctu_pkg::REG_N_CRIT, {1'b0, nc});
        reg_write(ctu_pkg::REG_N_PEAK, {1'b0, np});
        reg_write(ctu_pkg::REG_S_STRENGTH, ss);
        reg_write(ctu_pkg::REG_S_CRIT, {1'b0, sc});
        reg_write(ctu_pkg::REG_S_PEAK, {1'b0, sp});
        reg_write(ctu_pkg::REG_MIX, {28'b0, mx});
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: defaults, edges of the law and of the fields
        send_request(10'd0, 32'd0, 32'd0, 16'sd16384, 16'd0, 16'd0,
                     16'd0, 16'sd16384, 16'd0, 32'h0001_0000);
        // closed normal opening
        send_request(10'd1, 32'h8000_0000, 32'h0010_0000, -16'sd16384, 16'd0, 16'd0,
                     16'd0, -16'sd16384, 16'd0, 32'hFFFF_FFFF);
        // opening inside the rising branch, then softening
        send_request(10'd2, 32'h0010_0000, 32'hFFF0_0000, 16'd0, 16'd0, 16'sd16384,
                     16'sd16384, 16'd0, 16'd0, 32'h0002_0000);
        send_request(10'd2, 32'h0080_0000, 32'd0, 16'd0, 16'd0, 16'sd16384,
                     16'sd16384, 16'd0, 16'd0, 32'h0002_0000);
        // pure normal failure, then an already debonded segment
        send_request(10'd3, 32'h7FFF_FFFF, 32'd0, 16'sd16384, 16'sd16384, 16'sd16384,
                     16'sd16384, 16'sd16384, 16'sd16384, 32'hFFFF_FFFF);
        send_request(10'd3, 32'h0020_0000, 32'h0020_0000, 16'sd16384, 16'd0, 16'd0,
                     16'd0, 16'sd16384, 16'd0, 32'h0001_0000);
        // pure shear failure, then sliding of exactly critical size, both negative
        send_request(10'd4, 32'd0, 32'h8000_0000, 16'd0, 16'sd16384, 16'd0,
                     16'sd16384, 16'd0, 16'd0, 32'h0001_0000);
        send_request(10'd5, 32'd1, 32'hFF00_0000, 16'd0, 16'sd16384, 16'd0,
                     16'sd16384, 16'd0, 16'd0, 32'h0001_0000);
        // exactly critical, mixed-mode failure
        send_request(10'd6, 32'h0100_0000, 32'd0, 16'sd16384, 16'd0, 16'd0,
                     16'd0, 16'sd16384, 16'd0, 32'h0001_0000);
        send_request(10'd7, 32'h00A0_0000, 32'h00A0_0000, 16'sd11585, 16'sd11585, 16'd0,
                     -16'sd11585, 16'sd11585, 16'd0, 32'h0004_0000);
        send_request(10'd1023, 32'h0000_0001, 32'hFFFF_FFFF, -16'sd16384, -16'sd16384,
                     -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, 32'd0);
        send_request(10'd1023, 32'h00FF_FFFF, 32'h0000_0001, 16'sd16384, 16'd0, 16'd0,
                     16'd0, 16'd0, 16'sd16384, 32'hFFFF_FFFF);

        // hold off until every result is in
        drain();

        random_items(N_RANDOM / 6, 63);

        // strongest extremes: full strength, largest openings, high exponent
        load_regs(32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h0000_0001,
                  32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h0000_0001, 4'd8);
        random_items(N_RANDOM / 6, 127);

        // zero strength, criterion off, peaks now beyond the law for old segments
        load_regs(32'd0, 31'h0080_0000, 31'h0010_0000,
                  32'd0, 31'h0040_0000, 31'h0008_0000, 4'd0);
        random_items(N_RANDOM / 6, 127);

        // empty softening span, largest exponent
        load_regs(32'h0003_0000, 31'h0100_0000, 31'h0200_0000,
                  32'h0002_0000, 31'h0100_0000, 31'h0100_0000, 4'd15);
        random_items(N_RANDOM / 6, 255);

        // tiny openings, square criterion
        load_regs(32'h0010_0000, 31'h0000_1000, 31'h0000_0400,
                  32'h0000_8000, 31'h0000_0800, 31'h0000_0001, 4'd2);
        random_items(N_RANDOM / 6, 1023);

        // back to reset values
        load_regs(ctu_pkg::RST_STRENGTH, ctu_pkg::RST_CRIT, ctu_pkg::RST_PEAK,
                  ctu_pkg::RST_STRENGTH, ctu_pkg::RST_CRIT, ctu_pkg::RST_PEAK,
                  ctu_pkg::RST_MIX);
        random_items(N_RANDOM / 6, 63);

        drain();
        repeat (600) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/ctu_pkg.sv
sv/ctu_div.sv
sv/ctu_mem.sv
sv/cohesive_traction_update.sv
verif/cohesive_traction_update_test.sv
